[design/dtp_pkg.sv]
// Package for the DER TLV stream parser: byte roles, status codes, length
// byte limits and the per-byte result record. No dependencies.
`default_nettype none

package dtp_pkg;

    // Longest long-form length field accepted, in bytes
    localparam int unsigned MaxLenBytes = 4;
    // Width of the length byte counters; holds MaxLenBytes itself
    localparam int unsigned CntW        = $clog2(MaxLenBytes + 1);

    localparam logic [7:0] LongFormBit = 8'h80;
    localparam logic [6:0] LenCntMask  = 7'h7F;

    typedef enum logic [1:0] {
        ROLE_TAG     = 2'd0,
        ROLE_LENGTH  = 2'd1,
        ROLE_VALUE   = 2'd2,
        ROLE_DISCARD = 2'd3
    } t_role;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_TOO_SMALL = 2'd1,
        ST_BAD_LEN   = 2'd2,
        ST_RSVD      = 2'd3
    } t_status;

    // Result of one byte
    typedef struct packed {
        t_role       byte_role;
        logic [7:0]  elem_tag;
        logic [31:0] elem_length;
        logic        header_done;
        logic        element_done;
        t_status     status;
    } t_result;

    // Input byte as held in the input register
    typedef struct packed {
        logic [7:0] in_byte;
        logic       buffer_last;
    } t_in_item;

endpackage

`default_nettype wire

[design/dtp_in_stage.sv]
// Input register of the DER TLV stream parser: holds one transaction until
// the parser core consumes it. Depends on dtp_pkg.
`default_nettype none

module dtp_in_stage (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    output logic             o_ready,
    input  dtp_pkg::t_in_item i_item,
    output logic             o_valid,
    input  wire              i_take,
    output dtp_pkg::t_in_item o_item
);
    import dtp_pkg::*;

    logic     r_valid;
    t_in_item r_item;

    // Accept when empty or when the held transaction leaves this cycle
    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    // Hold the valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Load the payload on acceptance
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

`default_nettype wire

[design/dtp_core.sv]
// Parser core of the DER TLV stream parser: element state and the one-step
// labelling logic for a byte. Depends on dtp_pkg.
`default_nettype none

module dtp_core (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_en,
    input  dtp_pkg::t_in_item i_item,
    output dtp_pkg::t_result  o_res
);
    import dtp_pkg::*;

    typedef enum logic [1:0] {
        PH_TAG   = 2'd0,
        PH_LEN1  = 2'd1,
        PH_LENN  = 2'd2,
        PH_VALUE = 2'd3
    } t_phase;

    t_phase            r_phase,  n_phase;
    logic [7:0]        r_tag,    n_tag;
    logic [31:0]       r_acc,    n_acc;
    logic [CntW-1:0]   r_left,   n_left;
    logic [CntW-1:0]   r_total,  n_total;
    logic              r_fzero,  n_fzero;
    logic [31:0]       r_vleft,  n_vleft;
    logic              r_err,    n_err;
    logic              r_ovf,    n_ovf;

    logic [7:0]        b;
    logic              last;
    logic [6:0]        lcnt;
    logic [31:0]       acc_sh;
    logic [CntW-1:0]   left_dec;
    logic              fz;
    logic              ovf;
    logic [31:0]       hdr_len;
    logic              hdr_fin;
    t_result           res;

    assign b    = i_item.in_byte;
    assign last = i_item.buffer_last;
    assign lcnt = b[6:0] & LenCntMask;

    // Step one byte through the element state
    always_comb begin
        n_phase  = r_phase;
        n_tag    = r_tag;
        n_acc    = r_acc;
        n_left   = r_left;
        n_total  = r_total;
        n_fzero  = r_fzero;
        n_vleft  = r_vleft;
        n_err    = r_err;
        n_ovf    = r_ovf;
        acc_sh   = {r_acc[23:0], b};
        left_dec = (r_left != '0) ? r_left - 1'b1 : r_left;
        fz       = (r_left == r_total) ? (b == 8'h00) : r_fzero;
        ovf      = r_ovf || (r_acc[31:24] != 8'h00);
        hdr_len  = 32'd0;
        hdr_fin  = 1'b0;

        res.byte_role    = ROLE_DISCARD;
        res.elem_tag     = r_tag;
        res.elem_length  = 32'd0;
        res.header_done  = 1'b0;
        res.element_done = 1'b0;
        res.status       = ST_OK;

        if (!r_err) begin
            unique case (r_phase)
                PH_TAG: begin
                    res.byte_role = ROLE_TAG;
                    res.elem_tag  = b;
                    n_tag         = b;
                    if (last) begin
                        res.status = ST_TOO_SMALL;
                    end else begin
                        n_phase = PH_LEN1;
                    end
                end
                PH_LEN1: begin
                    res.byte_role = ROLE_LENGTH;
                    if ((b & LongFormBit) == 8'h00) begin
                        hdr_fin = 1'b1;
                        hdr_len = {24'd0, b};
                    end else if (lcnt == 7'd0 || lcnt > 7'(MaxLenBytes)) begin
                        res.status = ST_BAD_LEN;
                    end else if (last) begin
                        res.status = ST_TOO_SMALL;
                    end else begin
                        n_left  = lcnt[CntW-1:0];
                        n_total = lcnt[CntW-1:0];
                        n_acc   = 32'd0;
                        n_ovf   = 1'b0;
                        n_fzero = 1'b0;
                        n_phase = PH_LENN;
                    end
                end
                PH_LENN: begin
                    res.byte_role = ROLE_LENGTH;
                    n_fzero = fz;
                    n_ovf   = ovf;
                    n_acc   = acc_sh;
                    n_left  = left_dec;
                    if (left_dec != '0) begin
                        if (last) begin
                            res.status = ST_TOO_SMALL;
                        end
                    end else if ((r_total > CntW'(1) && fz) || ovf) begin
                        res.status = ST_BAD_LEN;
                    end else begin
                        hdr_fin = 1'b1;
                        hdr_len = acc_sh;
                    end
                end
                PH_VALUE: begin
                    res.byte_role   = ROLE_VALUE;
                    res.elem_length = r_acc;
                    if (r_vleft > 32'd1 && last) begin
                        res.status = ST_TOO_SMALL;
                    end
                    n_vleft = (r_vleft != 32'd0) ? r_vleft - 32'd1 : r_vleft;
                    if (r_vleft <= 32'd1) begin
                        res.element_done = 1'b1;
                        n_phase          = PH_TAG;
                    end
                end
                default: begin
                    n_phase = PH_TAG;
                end
            endcase

            // Close the header: zero length also ends the element
            if (hdr_fin) begin
                n_acc           = hdr_len;
                res.header_done = 1'b1;
                res.elem_length = hdr_len;
                if (hdr_len == 32'd0) begin
                    res.element_done = 1'b1;
                    n_phase          = PH_TAG;
                end else begin
                    n_vleft = hdr_len;
                    n_phase = PH_VALUE;
                    if (last) begin
                        res.status = ST_TOO_SMALL;
                    end
                end
            end

            if (res.status != ST_OK) begin
                n_err = 1'b1;
            end
        end

        // Drop all element state at the end of a buffer
        if (last) begin
            n_phase = PH_TAG;
            n_tag   = 8'd0;
            n_acc   = 32'd0;
            n_left  = '0;
            n_total = '0;
            n_fzero = 1'b0;
            n_vleft = 32'd0;
            n_err   = 1'b0;
            n_ovf   = 1'b0;
        end
    end

    assign o_res = res;

    // Hold element state; advance when a transaction is consumed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_TAG;
            r_tag   <= 8'd0;
            r_acc   <= 32'd0;
            r_left  <= '0;
            r_total <= '0;
            r_fzero <= 1'b0;
            r_vleft <= 32'd0;
            r_err   <= 1'b0;
            r_ovf   <= 1'b0;
        end else if (i_en) begin
            r_phase <= n_phase;
            r_tag   <= n_tag;
            r_acc   <= n_acc;
            r_left  <= n_left;
            r_total <= n_total;
            r_fzero <= n_fzero;
            r_vleft <= n_vleft;
            r_err   <= n_err;
            r_ovf   <= n_ovf;
        end
    end

endmodule

`default_nettype wire

[design/der_tlv_stream_parser_top.sv]
// Top level of the DER TLV stream parser: input register, parser core and
// result register. Depends on dtp_pkg, dtp_in_stage and dtp_core.
`default_nettype none

// DER TLV stream parser. Feed the encoded buffer one byte per transaction,
// with i_buffer_last set on its final byte; every byte yields exactly one
// result labelling it as tag, length, value or discarded. Short-form and
// long-form lengths of 1 to MaxLenBytes bytes are decoded; status reports a
// truncated buffer or an invalid length on the byte where it is found, and
// the rest of that buffer is discarded. Throughput is one byte per clock
// while results are taken: a byte passes from the input register through
// one step of the parser core into the result register. The input side
// stays ready while a result waits, as long as the input register is free.
module der_tlv_stream_parser_top (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_ready,
    input  wire  [7:0]  i_in_byte,
    input  wire         i_buffer_last,
    output logic        o_out_valid,
    input  wire         i_out_ready,
    output logic [1:0]  o_byte_role,
    output logic [7:0]  o_elem_tag,
    output logic [31:0] o_elem_length,
    output logic        o_header_done,
    output logic        o_element_done,
    output logic [1:0]  o_status
);
    import dtp_pkg::*;

    t_in_item in_item;
    t_in_item held_item;
    logic     held_valid;
    logic     take;
    t_result  step_res;
    logic     r_out_valid;
    t_result  r_out;

    assign in_item.in_byte     = i_in_byte;
    assign in_item.buffer_last = i_buffer_last;

    dtp_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (in_item),
        .o_valid (held_valid),
        .i_take  (take),
        .o_item  (held_item)
    );

    // Consume the held transaction when the result register is free
    assign take = held_valid && (!r_out_valid || i_out_ready);

    dtp_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (take),
        .i_item  (held_item),
        .o_res   (step_res)
    );

    // Hold the result until the transaction is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || i_out_ready) begin
            r_out_valid <= held_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= step_res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_byte_role    = r_out.byte_role;
    assign o_elem_tag     = r_out.elem_tag;
    assign o_elem_length  = r_out.elem_length;
    assign o_header_done  = r_out.header_done;
    assign o_element_done = r_out.element_done;
    assign o_status       = r_out.status;

`ifndef SYNTHESIS
    // An error is reported on a tag or length or value byte, never a discard
    a_status_role: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status != ST_OK) |-> (r_out.byte_role != ROLE_DISCARD))
        else $error("status raised on a discarded byte");

    // The header completes only on a length byte
    a_hdr_role: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.header_done) |-> (r_out.byte_role == ROLE_LENGTH))
        else $error("header_done on a non-length byte");

    // An element never completes on its tag byte or on a discarded byte
    a_done_role: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.element_done) |->
        (r_out.byte_role == ROLE_LENGTH || r_out.byte_role == ROLE_VALUE))
        else $error("element_done on a tag or discarded byte");

    // The core consumes a byte only when one is held
    a_take_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |-> held_valid)
        else $error("core advanced with no byte held");
`endif

endmodule

`default_nettype wire

[dv/dtp_tlv_checker.sv]
`timescale 1ns / 100ps
// Result checker for the DER TLV stream parser: watches both channels, labels
// each accepted byte with its own parser model and compares. Depends on dtp_pkg.
module dtp_tlv_checker (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    input  wire         i_in_ready,
    input  wire  [7:0]  i_in_byte,
    input  wire         i_buffer_last,
    input  wire         i_out_valid,
    input  wire         i_out_ready,
    input  wire  [1:0]  i_byte_role,
    input  wire  [7:0]  i_elem_tag,
    input  wire  [31:0] i_elem_length,
    input  wire         i_header_done,
    input  wire         i_element_done,
    input  wire  [1:0]  i_status,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked,
    output int          o_too_small,
    output int          o_bad_len
);
    import dtp_pkg::*;

    typedef enum logic [1:0] {
        SEEK_TAG  = 2'd0,
        FIRST_LEN = 2'd1,
        MORE_LEN  = 2'd2,
        IN_VALUE  = 2'd3
    } t_parse_phase;

    // Model parser state
    t_parse_phase    phase;
    logic [7:0]      cur_tag;
    logic [31:0]     len_acc;
    logic [CntW-1:0] lb_left;
    logic [CntW-1:0] lb_total;
    logic            first_zero;
    logic [31:0]     val_left;
    logic            err_latched;
    logic            len_ovf;

    // Labels predicted for bytes whose result has not yet come out
    t_result         expected_labels[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
        o_too_small  = 0;
        o_bad_len    = 0;
    end

    function automatic void clear_parse();
        phase       = SEEK_TAG;
        cur_tag     = '0;
        len_acc     = '0;
        lb_left     = '0;
        lb_total    = '0;
        first_zero  = 1'b0;
        val_left    = '0;
        err_latched = 1'b0;
        len_ovf     = 1'b0;
    endfunction

    // Header complete: report the length and move to value or next tag
    function automatic t_result close_header(input logic [31:0] len, input logic last,
                                             input t_result r_in);
        t_result r;
        r             = r_in;
        len_acc       = len;
        r.header_done = 1'b1;
        r.elem_length = len;
        if (len == 32'd0) begin
            r.element_done = 1'b1;
            phase          = SEEK_TAG;
        end else begin
            val_left = len;
            phase    = IN_VALUE;
            if (last)
                r.status = ST_TOO_SMALL;
        end
        return r;
    endfunction

    // Label one byte of the buffer and advance the model
    function automatic t_result label_byte(input logic [7:0] b, input logic last);
        t_result    r;
        logic [6:0] n;
        r.byte_role    = ROLE_DISCARD;
        r.elem_tag     = cur_tag;
        r.elem_length  = '0;
        r.header_done  = 1'b0;
        r.element_done = 1'b0;
        r.status       = ST_OK;
        n              = b[6:0] & LenCntMask;
        if (!err_latched) begin
            case (phase)
                SEEK_TAG: begin
                    r.byte_role = ROLE_TAG;
                    cur_tag     = b;
                    r.elem_tag  = b;
                    if (last)
                        r.status = ST_TOO_SMALL;
                    else
                        phase = FIRST_LEN;
                end
                FIRST_LEN: begin
                    r.byte_role = ROLE_LENGTH;
                    if ((b & LongFormBit) == 8'h00) begin
                        r = close_header({24'd0, b}, last, r);
                    end else if (n == 7'd0 || n > MaxLenBytes) begin
                        r.status = ST_BAD_LEN;
                    end else if (last) begin
                        r.status = ST_TOO_SMALL;
                    end else begin
                        lb_left    = n[CntW-1:0];
                        lb_total   = n[CntW-1:0];
                        len_acc    = '0;
                        len_ovf    = 1'b0;
                        first_zero = 1'b0;
                        phase      = MORE_LEN;
                    end
                end
                MORE_LEN: begin
                    r.byte_role = ROLE_LENGTH;
                    if (lb_left == lb_total)
                        first_zero = (b == 8'h00);
                    if (len_acc[31:24] != 8'h00)
                        len_ovf = 1'b1;
                    len_acc = {len_acc[23:0], b};
                    if (lb_left != '0)
                        lb_left = lb_left - 1'b1;
                    if (lb_left != '0) begin
                        if (last)
                            r.status = ST_TOO_SMALL;
                    end else if ((lb_total > 1 && first_zero) || len_ovf) begin
                        r.status = ST_BAD_LEN;
                    end else begin
                        r = close_header(len_acc, last, r);
                    end
                end
                default: begin
                    r.byte_role   = ROLE_VALUE;
                    r.elem_length = len_acc;
                    if (val_left != 32'd0)
                        val_left = val_left - 32'd1;
                    if (val_left == 32'd0) begin
                        r.element_done = 1'b1;
                        phase          = SEEK_TAG;
                    end else if (last) begin
                        r.status = ST_TOO_SMALL;
                    end
                end
            endcase
            if (r.status != ST_OK)
                err_latched = 1'b1;
        end
        // End of buffer: start afresh with a tag
        if (last)
            clear_parse();
        return r;
    endfunction

    // Predict on input transactions, compare on output transactions
    always @(posedge i_clk) begin : watch
        t_result want;
        int      errs;
        errs = 0;
        if (!i_rst_n) begin
            clear_parse();
            expected_labels.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                want = label_byte(i_in_byte, i_buffer_last);
                expected_labels.push_back(want);
                if (want.status == ST_TOO_SMALL)
                    o_too_small <= o_too_small + 1;
                if (want.status == ST_BAD_LEN)
                    o_bad_len <= o_bad_len + 1;
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_labels.size() == 0) begin
                    $error("unexpected result: role %0d tag %0h status %0d",
                           i_byte_role, i_elem_tag, i_status);
                    errs++;
                end else begin
                    want = expected_labels.pop_front();
                    if (i_byte_role !== want.byte_role) begin
                        $error("byte_role: expected %0d, got %0d", want.byte_role, i_byte_role);
                        errs++;
                    end
                    if (i_elem_tag !== want.elem_tag) begin
                        $error("elem_tag: expected %0h, got %0h", want.elem_tag, i_elem_tag);
                        errs++;
                    end
                    if (i_elem_length !== want.elem_length) begin
                        $error("elem_length: expected %0d, got %0d",
                               want.elem_length, i_elem_length);
                        errs++;
                    end
                    if (i_header_done !== want.header_done) begin
                        $error("header_done: expected %0d, got %0d",
                               want.header_done, i_header_done);
                        errs++;
                    end
                    if (i_element_done !== want.element_done) begin
                        $error("element_done: expected %0d, got %0d",
                               want.element_done, i_element_done);
                        errs++;
                    end
                    if (i_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, i_status);
                        errs++;
                    end
                    o_checked <= o_checked + 1;
                end
            end
        end
        o_fail_count <= o_fail_count + errs;
        o_pending    <= expected_labels.size();
    end

endmodule

[dv/der_tlv_stream_parser_top_tb.sv]
`timescale 1ns / 100ps
// Testbench top for the DER TLV stream parser: clock, reset, byte stimulus,
// receiver stalls and verdict. Depends on dtp_pkg, the parser and dtp_tlv_checker.
module der_tlv_stream_parser_top_tb;
    import dtp_pkg::*;

    localparam int ItemTarget    = 1350;
    localparam int WatchdogLimit = 4000;
    localparam int LongHoldLen   = 400;
    localparam int DirCount      = 25;

    // Receiver stall patterns
    localparam int RX_ALWAYS   = 0;
    localparam int RX_COIN     = 1;
    localparam int RX_SPARSE   = 2;
    localparam int RX_PERIODIC = 3;

    // Directed buffers: truncated tag, zero length then one-byte long form,
    // padded long form, indefinite form, too many length bytes, truncation
    // over a padded long form, truncated value
    localparam logic [8*DirCount-1:0] DirBytes = {
        8'h30,
        8'h05, 8'h00, 8'hFF, 8'h81, 8'h02, 8'hAB, 8'hCD,
        8'h04, 8'h82, 8'h00, 8'h01, 8'h55,
        8'h30, 8'h80, 8'h00,
        8'h30, 8'h85, 8'h01,
        8'h04, 8'h82, 8'h00,
        8'h02, 8'h03, 8'h7F
    };
    localparam logic [DirCount-1:0] DirLast = 25'b1000000100001001001001001;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_in_byte;
    logic        i_buffer_last;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [1:0]  o_byte_role;
    logic [7:0]  o_elem_tag;
    logic [31:0] o_elem_length;
    logic        o_header_done;
    logic        o_element_done;
    logic [1:0]  o_status;

    int fail_count;
    int pending;
    int checked;
    int too_small_cnt;
    int bad_len_cnt;

    int items_sent  = 0;
    int frames_sent = 0;
    int burst_left  = 0;
    int idle_cycles = 0;
    bit long_hold_req   = 1'b0;
    bit long_hold_taken = 1'b0;
    int hold_cnt  = 0;
    int rx_mode   = RX_ALWAYS;
    int mode_left = 0;
    int rx_tick   = 0;

    logic [7:0] frame_q[$];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    der_tlv_stream_parser_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_in_byte      (i_in_byte),
        .i_buffer_last  (i_buffer_last),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_byte_role    (o_byte_role),
        .o_elem_tag     (o_elem_tag),
        .o_elem_length  (o_elem_length),
        .o_header_done  (o_header_done),
        .o_element_done (o_element_done),
        .o_status       (o_status)
    );

    dtp_tlv_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_in_byte      (i_in_byte),
        .i_buffer_last  (i_buffer_last),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_byte_role    (o_byte_role),
        .i_elem_tag     (o_elem_tag),
        .i_elem_length  (o_elem_length),
        .i_header_done  (o_header_done),
        .i_element_done (o_element_done),
        .i_status       (o_status),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_checked      (checked),
        .o_too_small    (too_small_cnt),
        .o_bad_len      (bad_len_cnt)
    );

    // Receiver: one long hold-off on request, otherwise a changing stall pattern
    always @(negedge i_clk) begin
        if (long_hold_req && !long_hold_taken) begin
            long_hold_taken = 1'b1;
            hold_cnt        = LongHoldLen;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            i_out_ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode   = $urandom_range(RX_ALWAYS, RX_PERIODIC);
                mode_left = $urandom_range(32, 256);
            end
            mode_left--;
            rx_tick++;
            case (rx_mode)
                RX_ALWAYS:   i_out_ready <= 1'b1;
                RX_COIN:     i_out_ready <= ($urandom_range(0, 1) == 1);
                RX_SPARSE:   i_out_ready <= ($urandom_range(0, 3) == 0);
                default:     i_out_ready <= ((rx_tick % 3) == 0);
            endcase
        end
    end

    // Watchdog: end the run if no transaction moves for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchdogLimit) begin
            $display("no transaction for %0d cycles", WatchdogLimit);
            $display("der_tlv_stream_parser_top test failed");
            $finish;
        end
    end

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // Offer one byte; open a new burst after a random gap when the last one ends
    task automatic put_byte(input logic [7:0] b, input logic last);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 15) == 0) ? 300 : $urandom_range(1, 24);
            if (gap > 0) begin
                @(negedge i_clk) i_in_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        @(negedge i_clk);
        i_in_valid    <= 1'b1;
        i_in_byte     <= b;
        i_buffer_last <= last;
        do @(posedge i_clk); while (!o_in_ready);
        burst_left--;
        items_sent++;
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_q.size(); i++)
            put_byte(frame_q[i], i == frame_q.size() - 1);
        frames_sent++;
    endtask

    // Append a long-form length: count byte then nlen big-endian bytes
    task automatic push_long_form(input logic [31:0] len, input int nlen);
        logic [7:0] hdr;
        hdr = 8'(nlen);
        frame_q.push_back(hdr | LongFormBit);
        for (int i = nlen - 1; i >= 0; i--)
            frame_q.push_back(len[8*i +: 8]);
    endtask

    // Build one buffer: mostly well-formed elements, some broken or cut short
    task automatic make_frame();
        int          kind;
        int          n_elem;
        int          pick;
        int          nval;
        int          cut;
        logic [31:0] len;
        logic [7:0]  lb;
        bit          stop;
        frame_q.delete();
        stop = 1'b0;
        kind = $urandom_range(0, 99);
        if (kind < 6) begin
            repeat ($urandom_range(1, 6)) frame_q.push_back(rand_byte());
        end else begin
            n_elem = $urandom_range(1, 4);
            for (int e = 0; e < n_elem && !stop; e++) begin
                frame_q.push_back(rand_byte());
                pick = $urandom_range(0, 99);
                if (pick < 45) begin
                    len = $urandom_range(0, 6);
                    frame_q.push_back(len[7:0]);
                    nval = len;
                end else if (pick < 55) begin
                    len = $urandom_range(100, 127);
                    frame_q.push_back(len[7:0]);
                    nval = len;
                end else if (pick < 78) begin
                    len = $urandom_range(0, 300);
                    push_long_form(len, (len > 255) ? 2 : 1);
                    nval = len;
                end else if (pick < 88) begin
                    // wide length, far more than the buffer holds
                    len = $urandom();
                    push_long_form(len, MaxLenBytes);
                    nval = $urandom_range(0, 3);
                    stop = 1'b1;
                end else begin
                    case ($urandom_range(0, 2))
                        0: frame_q.push_back(LongFormBit);
                        1: begin
                            lb = 8'($urandom_range(MaxLenBytes + 1, 127));
                            frame_q.push_back(lb | LongFormBit);
                        end
                        default: push_long_form({16'd0, rand_byte(), rand_byte()}, 3);
                    endcase
                    nval = $urandom_range(0, 3);
                end
                repeat (nval) frame_q.push_back(rand_byte());
            end
            // cut some buffers short at a random point
            if (!stop && $urandom_range(0, 9) == 0 && frame_q.size() > 1) begin
                cut = $urandom_range(1, frame_q.size() - 1);
                repeat (cut) void'(frame_q.pop_back());
            end
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in_byte     = 8'h00;
        i_buffer_last = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // Directed buffers
        for (int i = 0; i < DirCount; i++)
            put_byte(DirBytes[8*(DirCount-1-i) +: 8], DirLast[DirCount-1-i]);

        // Random buffers; halfway through, have the receiver hold off
        while (items_sent < ItemTarget) begin
            make_frame();
            send_frame();
            if (!long_hold_req && items_sent >= ItemTarget / 2)
                long_hold_req = 1'b1;
        end
        @(negedge i_clk) i_in_valid <= 1'b0;

        // Drain outstanding results, then allow for the pipeline
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Sent %0d bytes in %0d buffers, %0d results checked.",
                 items_sent, frames_sent + 7, checked);
        $display("Flagged %0d truncated and %0d invalid-length elements.",
                 too_small_cnt, bad_len_cnt);
        if (fail_count == 0)
            $display("der_tlv_stream_parser_top test passed");
        else
            $display("der_tlv_stream_parser_top test failed");
        $finish;
    end

endmodule
